[rtl/cpcp_pkg.sv]
// Package for the character pair codeword packer.
// Holds the character table, code mapping function and the job type.
// No dependencies.
package cpcp_pkg;

    localparam int CODE_W          = 6;
    localparam int WORD_W          = 2 * CODE_W;
    localparam int CHAR_W          = 8;
    localparam int TABLE_DEPTH     = 1 << CODE_W;
    localparam int CPCP_QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] UNKNOWN_CODE = CODE_W'(28);
    localparam logic [CODE_W-1:0] NULL_CODE    = '0;
    localparam logic [CHAR_W-1:0] NULL_CHAR    = '0;

    localparam logic [CHAR_W-1:0] CHAR_TABLE [TABLE_DEPTH] = '{
        8'h00, 8'h08, 8'h0d, 8'h20, 8'h21, 8'h22, 8'h27, 8'h28,
        8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h30,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h3a, 8'h3b, 8'h3d, 8'h3f, 8'h40, 8'h41, 8'h42,
        8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a,
        8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a,
        8'h5c, 8'h5e, 8'h60, 8'h7e, 8'hff, 8'hff, 8'hff, 8'hff
    };

    // Reverse lookup, lowest matching index wins; reduces to a 256-entry ROM.
    function automatic logic [CODE_W-1:0] map_char(input logic [CHAR_W-1:0] c);
        logic [CODE_W-1:0] code;
        code = UNKNOWN_CODE;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (CHAR_TABLE[i] == c) begin
                code = CODE_W'(i);
            end
        end
        if (c == NULL_CHAR) begin
            code = NULL_CODE;
        end
        return code;
    endfunction

    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic              two;
        logic              msg_end;
    } job_t;

endpackage

[rtl/cpcp_front.sv]
// Front end: maps characters to codes, applies repeat and pad rules, pairs codes.
// Emits one job (one or two codewords) per request that completes a word.
// Depends on cpcp_pkg.
module cpcp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cpcp_pkg::CHAR_W-1:0]   s_char_in,
    input  logic                          s_msg_end,
    input  logic                          s_valid,
    output logic                          s_ready,
    output logic                          job_valid,
    output cpcp_pkg::job_t                job,
    input  logic                          job_ready
);
    import cpcp_pkg::*;

    logic [CODE_W-1:0] held_reg,  held_next;
    logic              phase_reg, phase_next;
    logic [CHAR_W-1:0] prev_reg,  prev_next;

    logic [CODE_W-1:0] code;
    logic              rep;
    logic [CODE_W-1:0] slot_code [3];
    logic              slot_en   [3];
    logic [1:0]        n;
    logic              accept;

    assign code   = map_char(s_char_in);
    assign rep    = (prev_reg != NULL_CHAR) && (prev_reg == s_char_in);
    assign s_ready = job_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        held_next   = held_reg;
        phase_next  = phase_reg;
        n           = '0;
        job.word0   = '0;
        job.word1   = '0;
        job.msg_end = s_msg_end;
        slot_code[0] = code;
        slot_code[1] = NULL_CODE;
        slot_code[2] = NULL_CODE;
        slot_en[0]   = 1'b1;
        slot_en[1]   = rep;
        slot_en[2]   = s_msg_end;
        for (int i = 0; i < 3; i++) begin
            if (slot_en[i] && (i != 2 || phase_next)) begin
                if (!phase_next) begin
                    held_next  = slot_code[i];
                    phase_next = 1'b1;
                end else begin
                    if (n == 2'd0) begin
                        job.word0 = {slot_code[i], held_next};
                    end else begin
                        job.word1 = {slot_code[i], held_next};
                    end
                    n          = n + 2'd1;
                    phase_next = 1'b0;
                end
            end
        end
        job.two   = (n == 2'd2);
        job_valid = s_valid && (n != 2'd0);
        prev_next = s_msg_end ? NULL_CHAR : s_char_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            phase_reg <= 1'b0;
            prev_reg  <= '0;
        end else if (accept) begin
            held_reg  <= held_next;
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

[rtl/cpcp_queue.sv]
// Short job queue between front and back ends.
// Depends on cpcp_pkg.
module cpcp_queue #(
    parameter int DEPTH = cpcp_pkg::CPCP_QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  cpcp_pkg::job_t  in_job,
    output logic            out_valid,
    input  logic            out_ready,
    output cpcp_pkg::job_t  out_job
);
    import cpcp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

endmodule

[rtl/cpcp_back.sv]
// Back end: splits each job into codeword results in an output register.
// Depends on cpcp_pkg.
module cpcp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  cpcp_pkg::job_t                job,
    output logic [cpcp_pkg::WORD_W-1:0]   m_codeword,
    output logic                          m_run_last,
    output logic                          m_message_done,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import cpcp_pkg::*;

    logic              sub_reg,   sub_next;
    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;
    logic              done_reg;
    logic              load;
    logic              last;

    assign load      = job_valid && (!valid_reg || m_ready);
    assign last      = !job.two || sub_reg;
    assign job_ready = load && last;

    always_comb begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            sub_next   = !last;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= sub_reg ? job.word1 : job.word0;
            last_reg <= last;
            done_reg <= last && job.msg_end;
        end
    end

    assign m_valid        = valid_reg;
    assign m_codeword     = word_reg;
    assign m_run_last     = last_reg;
    assign m_message_done = done_reg;

endmodule

[rtl/char_pair_codeword_packer_core.sv]
// Channel   Dir  Ports                                         Request
// s_        in   s_char_in[7:0] s_msg_end s_valid s_ready       one character
// m_        out  m_codeword[11:0] m_run_last m_message_done     one codeword
//                m_valid m_ready
// Each character yields 0, 1 or 2 codewords; they leave the output
// register one per cycle while m_ready is high, and new characters are taken while the queue has room.
// The first codeword of a character is written into the job queue, then loaded into the output register.
// aresetn is synchronous, active low; it clears pairing state, queue and output.
// s_ready drops only when the job queue is full; m_ready low stalls the back end, which can fill the queue.
// Top level: front end, job queue, back end. Depends on cpcp_pkg.
module char_pair_codeword_packer_core #(
    parameter int QUEUE_DEPTH = cpcp_pkg::CPCP_QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cpcp_pkg::CHAR_W-1:0]   s_char_in,
    input  logic                          s_msg_end,
    input  logic                          s_valid,
    output logic                          s_ready,
    output logic [cpcp_pkg::WORD_W-1:0]   m_codeword,
    output logic                          m_run_last,
    output logic                          m_message_done,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import cpcp_pkg::*;

    logic fq_valid, fq_ready;
    job_t fq_job;
    logic qb_valid, qb_ready;
    job_t qb_job;

    cpcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_char_in (s_char_in),
        .s_msg_end (s_msg_end),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .job_valid (fq_valid),
        .job       (fq_job),
        .job_ready (fq_ready)
    );

    cpcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    cpcp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (qb_valid),
        .job_ready      (qb_ready),
        .job            (qb_job),
        .m_codeword     (m_codeword),
        .m_run_last     (m_run_last),
        .m_message_done (m_message_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

endmodule

[rtl/cpcp_checker.sv]
// Port-level checks for char_pair_codeword_packer_core, bound to the top level.
// Depends on cpcp_pkg.
module cpcp_assertions (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [cpcp_pkg::WORD_W-1:0]   m_codeword,
    input logic                          m_run_last,
    input logic                          m_message_done,
    input logic                          m_valid,
    input logic                          m_ready
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("request withdrawn before accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_codeword))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_message_done || m_run_last))
        else $error("message end not on last result of request");

    a_second_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("second codeword of request not presented");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind char_pair_codeword_packer_core cpcp_assertions u_cpcp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_codeword     (m_codeword),
    .m_run_last     (m_run_last),
    .m_message_done (m_message_done),
    .m_valid        (m_valid),
    .m_ready        (m_ready)
);
